### hdl/pli_pkg.sv
package pli_pkg;

    localparam int POINTS_DEF = 16;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = 1;

    typedef enum logic [1:0] {
        K_LOAD,
        K_EVAL,
        K_DROP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  idx;
        logic [31:0] a;
        logic [31:0] b;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [32:0] mag;
        logic [31:0] dt;
        logic [31:0] dx;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [32:0] quo;
    } t_div_rsp;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_DIV
    } t_dstate;

    typedef enum logic [1:0] {
        B_IDLE,
        B_START,
        B_SCAN,
        B_WAIT
    } t_bstate;

endpackage

### hdl/pli_ram.sv
module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/pli_div.sv
module pli_div
    import pli_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    t_dstate     r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_mcand, n_mcand;
    logic [31:0] r_mplier, n_mplier;
    logic [31:0] r_dx, n_dx;
    logic [31:0] r_rem, n_rem;
    logic [32:0] r_low, n_low;
    logic [32:0] r_quo, n_quo;
    logic        r_done, n_done;
    logic [63:0] w_acc;
    logic [33:0] w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_dx     <= n_dx;
        r_rem    <= n_rem;
        r_low    <= n_low;
        r_quo    <= n_quo;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_dx     = r_dx;
        n_rem    = r_rem;
        n_low    = r_low;
        n_quo    = r_quo;
        n_done   = 1'b0;
        w_acc    = r_mplier[0] ? r_acc + r_mcand : r_acc;
        w_trial  = {1'b0, r_rem, r_low[32]} - {2'b00, r_dx};
        case (r_state)
            D_IDLE: begin
                if (i_req.start) begin
                    n_acc    = '0;
                    n_mcand  = {31'b0, i_req.mag};
                    n_mplier = i_req.dt;
                    n_dx     = i_req.dx;
                    n_cnt    = '0;
                    n_state  = D_MUL;
                end
            end
            D_MUL: begin
                n_acc    = w_acc;
                n_mcand  = {r_mcand[62:0], 1'b0};
                n_mplier = {1'b0, r_mplier[31:1]};
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    // quotient fits 33 bits, so the top of the product is below dx
                    n_rem   = {1'b0, w_acc[63:33]};
                    n_low   = w_acc[32:0];
                    n_cnt   = '0;
                    n_state = D_DIV;
                end
            end
            D_DIV: begin
                n_low = {r_low[31:0], 1'b0};
                if (!w_trial[33]) begin
                    n_rem = w_trial[31:0];
                    n_quo = {r_quo[31:0], 1'b1};
                end else begin
                    n_rem = {r_rem[30:0], r_low[32]};
                    n_quo = {r_quo[31:0], 1'b0};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd32) begin
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

### hdl/pli_front.sv
module pli_front
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [3:0]  i_point_index,
    input  logic [31:0] i_point_time,
    input  logic [31:0] i_point_value,
    input  logic [31:0] i_eval_time,
    output logic        o_item_valid,
    output t_item       o_item,
    input  logic        i_pop
);

    t_item            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_AW:0]    r_cnt;
    t_item            w_item;
    logic             w_push;

    always_comb begin
        w_item.idx = i_point_index;
        w_item.b   = i_point_value;
        if (i_req_type) begin
            w_item.kind = K_EVAL;
            w_item.a    = i_eval_time;
        end else begin
            // drop loads aimed past the table
            w_item.kind = (32'(i_point_index) < 32'(MAX_POINTS)) ? K_LOAD : K_DROP;
            w_item.a    = i_point_time;
        end
    end

    assign o_in_ready   = (r_cnt != (Q_AW+1)'(Q_DEPTH));
    assign w_push       = i_in_valid && o_in_ready && (w_item.kind != K_DROP);
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(w_push) - (Q_AW+1)'(i_pop);
        end
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

endmodule

### hdl/pli_back.sv
module pli_back
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [4:0]         i_point_count,
    input  logic               i_item_valid,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value,
    output logic signed [31:0] o_next_break_time,
    output logic               o_next_break_valid
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    t_bstate             r_state, n_state;
    logic [IW-1:0]       r_idx, n_idx;
    logic [31:0]         r_t, n_t;
    logic [31:0]         r_pt, n_pt;
    logic [31:0]         r_pv, n_pv;
    logic                r_neg, n_neg;
    logic                r_ov, n_ov;
    logic [31:0]         r_oval, n_oval;
    logic [31:0]         r_onbt, n_onbt;
    logic                r_onbv, n_onbv;

    logic [CW-1:0]       w_n;
    logic                w_we;
    logic [IW-1:0]       w_raddr;
    logic [63:0]         w_rdata;
    logic signed [31:0]  w_rt, w_rv;
    logic signed [32:0]  w_dy, w_dt, w_dx;
    logic signed [34:0]  w_sum;
    t_div_req            w_dreq;
    t_div_rsp            w_drsp;

    assign w_n = (32'(i_point_count) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                        : CW'(i_point_count);
    assign w_rt = w_rdata[63:32];
    assign w_rv = w_rdata[31:0];
    assign w_dy = {w_rv[31], w_rv} - {r_pv[31], r_pv};
    assign w_dt = {r_t[31], r_t} - {r_pt[31], r_pt};
    assign w_dx = {w_rt[31], w_rt} - {r_pt[31], r_pt};
    assign w_raddr = (r_state == B_START) ? '0 : IW'(32'(r_idx) + 32'd1);

    pli_ram #(
        .WIDTH (64),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IW'(i_item.idx)),
        .i_wdata ({i_item.a, i_item.b}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_idx  <= n_idx;
        r_t    <= n_t;
        r_pt   <= n_pt;
        r_pv   <= n_pv;
        r_neg  <= n_neg;
        r_oval <= n_oval;
        r_onbt <= n_onbt;
        r_onbv <= n_onbv;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_t     = r_t;
        n_pt    = r_pt;
        n_pv    = r_pv;
        n_neg   = r_neg;
        n_ov    = r_ov && !i_out_ready;
        n_oval  = r_oval;
        n_onbt  = r_onbt;
        n_onbv  = r_onbv;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_dreq  = '0;
        w_sum   = r_neg ? {{3{r_pv[31]}}, r_pv} - {2'b00, w_drsp.quo}
                        : {{3{r_pv[31]}}, r_pv} + {2'b00, w_drsp.quo};
        case (r_state)
            B_IDLE: begin
                if (i_item_valid) begin
                    case (i_item.kind)
                        K_LOAD: begin
                            o_pop = 1'b1;
                            w_we  = 1'b1;
                        end
                        K_EVAL: begin
                            // hold the eval until the output word is free
                            if (!r_ov) begin
                                o_pop = 1'b1;
                                n_t   = i_item.a;
                                if (w_n == '0) begin
                                    n_ov   = 1'b1;
                                    n_oval = '0;
                                    n_onbt = '0;
                                    n_onbv = 1'b0;
                                end else begin
                                    n_idx   = '0;
                                    n_state = B_START;
                                end
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            B_START: begin
                n_state = B_SCAN;
            end
            B_SCAN: begin
                if (w_rt > $signed(r_t)) begin
                    n_onbt = w_rt;
                    n_onbv = 1'b1;
                    if (r_idx == '0) begin
                        n_ov    = 1'b1;
                        n_oval  = w_rv;
                        n_state = B_IDLE;
                    end else begin
                        w_dreq.start = 1'b1;
                        w_dreq.mag   = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
                        w_dreq.dt    = w_dt[31:0];
                        w_dreq.dx    = w_dx[31:0];
                        n_neg        = w_dy[32];
                        n_state      = B_WAIT;
                    end
                end else begin
                    n_pt = w_rt;
                    n_pv = w_rv;
                    if (32'(r_idx) + 32'd1 == 32'(w_n)) begin
                        // past the end: last value, no next break
                        n_ov    = 1'b1;
                        n_oval  = w_rv;
                        n_onbt  = '0;
                        n_onbv  = 1'b0;
                        n_state = B_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            B_WAIT: begin
                if (w_drsp.done) begin
                    n_ov    = 1'b1;
                    n_state = B_IDLE;
                    if (w_sum > 35'sd2147483647) begin
                        n_oval = 32'h7fffffff;
                    end else if (w_sum < -35'sd2147483648) begin
                        n_oval = 32'h80000000;
                    end else begin
                        n_oval = w_sum[31:0];
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    assign o_out_valid        = r_ov;
    assign o_value            = r_oval;
    assign o_next_break_time  = r_onbt;
    assign o_next_break_valid = r_onbv;

endmodule

### hdl/piecewise_linear_interpolator.sv
// Load word: queued, then written to the table when the back end pops it.
// Eval word: the scan reads one table slot a cycle until it stops; when it
// interpolates, a serial multiply and a restoring divide follow, and the
// quotient is handed back. Throughput: one eval at a time in the scan loop;
// loads drain at one per cycle while the back end is idle.
// Reset (synchronous, active low) clears point_count, the queue, the state
// machines and out_valid; table contents stay undefined until loaded.
module piecewise_linear_interpolator
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic [3:0]         i_point_index,
    input  logic signed [31:0] i_point_time,
    input  logic signed [31:0] i_point_value,
    input  logic signed [31:0] i_eval_time,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value,
    output logic signed [31:0] o_next_break_time,
    output logic               o_next_break_valid
);

    logic [4:0] r_point_count;
    logic       w_item_valid;
    t_item      w_item;
    logic       w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_data;
        end
    end

    pli_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_point_index (i_point_index),
        .i_point_time  (i_point_time),
        .i_point_value (i_point_value),
        .i_eval_time   (i_eval_time),
        .o_item_valid  (w_item_valid),
        .o_item        (w_item),
        .i_pop         (w_pop)
    );

    pli_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_point_count      (r_point_count),
        .i_item_valid       (w_item_valid),
        .i_item             (w_item),
        .o_pop              (w_pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_value            (o_value),
        .o_next_break_time  (o_next_break_time),
        .o_next_break_valid (o_next_break_valid)
    );

`ifndef SYNTHESIS
    a_inf_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_next_break_valid) |-> (o_next_break_time == 32'sd0))
        else $error("next break time not zero for infinity");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_point_count == 5'd0))
            |-> ((o_value == 32'sd0) && !o_next_break_valid))
        else $error("empty table gave nonzero result");

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_item_valid)
        else $error("pop from empty queue");
`endif

endmodule
